>>> design/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMTH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmth check failed");

// next-cycle implication
`define RMTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmth check failed");

`endif

>>> design/rmth_pkg.sv
`timescale 1ns / 1ps
package rmth_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int MED_W          = 17;
    localparam int HELD_W         = 11;
    localparam int HALF_DEPTH_DEF = 512;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        OP_NOP     = 2'b00,
        OP_INSERT  = 2'b01,
        OP_REPLACE = 2'b10
    } t_op;

    // operation broadcast along a row of cells
    typedef struct packed {
        t_op     op;
        t_sample x;
    } t_cmd;

endpackage

>>> design/rmth_cell.sv
`timescale 1ns / 1ps
module rmth_cell (
    input  logic             i_clk,
    input  rmth_pkg::t_cmd   i_cmd,
    input  logic             i_head,
    input  logic             i_vld,
    input  logic             i_prev_vld,
    input  rmth_pkg::t_sample i_prev_val,
    input  logic             i_next_vld,
    input  rmth_pkg::t_sample i_next_val,
    output rmth_pkg::t_sample o_val
);
    import rmth_pkg::*;

    t_sample r_val;
    t_sample n_val;
    logic    w_keep_self;
    logic    w_keep_prev;
    logic    w_keep_next;

    // a held word stays ahead of x unless x is strictly larger
    assign w_keep_self = i_vld && !(i_cmd.x > r_val);
    assign w_keep_prev = i_prev_vld && !(i_cmd.x > i_prev_val);
    assign w_keep_next = i_next_vld && !(i_cmd.x > i_next_val);

    always_comb begin
        n_val = r_val;
        unique case (i_cmd.op)
            OP_NOP: begin
                n_val = r_val;
            end
            OP_INSERT: begin
                priority if (w_keep_self) n_val = r_val;
                else if (i_head || w_keep_prev) n_val = i_cmd.x;
                else n_val = i_prev_val;
            end
            OP_REPLACE: begin
                // head drops out, row shifts towards the head, x slots in
                priority if (w_keep_next) n_val = i_next_val;
                else if (i_head || w_keep_self) n_val = i_cmd.x;
                else n_val = r_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

>>> design/rmth_chain.sv
`timescale 1ns / 1ps
module rmth_chain #(
    parameter int DEPTH = rmth_pkg::HALF_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  rmth_pkg::t_cmd             i_cmd,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    output rmth_pkg::t_sample          o_top
);
    import rmth_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sample w_val [DEPTH];
    logic    w_vld [DEPTH];

    // row kept sorted, largest at cell 0; occupancy decoded from the count
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_sample w_prev_val;
        logic    w_prev_vld;
        t_sample w_next_val;
        logic    w_next_vld;

        assign w_vld[g] = (i_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_prev_val = '0;
            assign w_prev_vld = 1'b0;
        end else begin : g_inner_prev
            assign w_prev_val = w_val[g-1];
            assign w_prev_vld = w_vld[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_val = '0;
            assign w_next_vld = 1'b0;
        end else begin : g_inner_next
            assign w_next_val = w_val[g+1];
            assign w_next_vld = w_vld[g+1];
        end

        rmth_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (i_cmd),
            .i_head     (g == 0),
            .i_vld      (w_vld[g]),
            .i_prev_vld (w_prev_vld),
            .i_prev_val (w_prev_val),
            .i_next_vld (w_next_vld),
            .i_next_val (w_next_val),
            .o_val      (w_val[g])
        );
    end

    assign o_top = w_val[0];

endmodule

>>> design/running_median_two_heaps.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// sample    in         start high, busy low i_sample
// median    out        o_strobe (1 cycle)   o_median_x2, o_dropped, o_samples_held
//
// Each word goes through accept, plan, one shift-insert across both cell rows
// and median add, in that order. The strobe comes in the same cycle in which
// busy drops, so the next word can be taken then.
// Reset clears counts, state and last median; the cells need no clearing.
// Results cannot be stalled: each one is shown for one cycle only.
`include "assert_macros.svh"
module running_median_two_heaps #(
    parameter int HALF_DEPTH = rmth_pkg::HALF_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rmth_pkg::t_sample                   i_sample,
    output logic                                o_strobe,
    output logic signed [rmth_pkg::MED_W-1:0]   o_median_x2,
    output logic                                o_dropped,
    output logic [rmth_pkg::HELD_W-1:0]         o_samples_held
);
    import rmth_pkg::*;

    localparam int CNT_W = $clog2(HALF_DEPTH + 1);
    localparam int TOT_W = CNT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_APPLY  = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    t_sample                   r_sample, n_sample;
    t_cmd                      r_lo_cmd, n_lo_cmd;
    t_cmd                      r_up_cmd, n_up_cmd;
    logic                      r_drop, n_drop;
    logic [CNT_W-1:0]          r_lo_cnt, n_lo_cnt;
    logic [CNT_W-1:0]          r_up_cnt, n_up_cnt;
    logic                      r_strobe, n_strobe;
    logic signed [MED_W-1:0]   r_median, n_median;
    logic                      r_dropped, n_dropped;
    logic [HELD_W-1:0]         r_held, n_held;

    t_sample                   w_lo_top;
    t_sample                   w_up_raw;
    t_sample                   w_up_top;
    logic                      w_even;
    logic                      w_full;
    logic [TOT_W-1:0]          w_total;

    // lower half: max-ordered row; upper half stored inverted so the same
    // max-ordered row gives a min-ordered set
    rmth_chain #(.DEPTH(HALF_DEPTH)) u_lower (
        .i_clk   (i_clk),
        .i_cmd   (r_lo_cmd),
        .i_count (r_lo_cnt),
        .o_top   (w_lo_top)
    );

    rmth_chain #(.DEPTH(HALF_DEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_cmd   (r_up_cmd),
        .i_count (r_up_cnt),
        .o_top   (w_up_raw)
    );

    assign w_up_top = ~w_up_raw;
    assign w_even   = (r_lo_cnt == r_up_cnt);
    assign w_full   = (r_lo_cnt == CNT_W'(HALF_DEPTH));
    assign w_total  = TOT_W'(r_lo_cnt) + TOT_W'(r_up_cnt);

    always_comb begin
        n_state   = r_state;
        n_sample  = r_sample;
        n_lo_cmd  = r_lo_cmd;
        n_up_cmd  = r_up_cmd;
        n_drop    = r_drop;
        n_lo_cnt  = r_lo_cnt;
        n_up_cnt  = r_up_cnt;
        n_strobe  = 1'b0;
        n_median  = r_median;
        n_dropped = r_dropped;
        n_held    = r_held;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sample = i_sample;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_drop      = 1'b0;
                n_lo_cmd.op = OP_NOP;
                n_lo_cmd.x  = r_sample;
                n_up_cmd.op = OP_NOP;
                n_up_cmd.x  = ~r_sample;
                if (w_even) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else if (r_up_cnt != '0 && r_sample > w_up_top) begin
                        // sample belongs above: upper top drops to the lower half
                        n_lo_cmd.op = OP_INSERT;
                        n_lo_cmd.x  = w_up_top;
                        n_up_cmd.op = OP_REPLACE;
                    end else begin
                        n_lo_cmd.op = OP_INSERT;
                    end
                end else begin
                    if (r_sample < w_lo_top) begin
                        n_lo_cmd.op = OP_REPLACE;
                        n_up_cmd.op = OP_INSERT;
                        n_up_cmd.x  = ~w_lo_top;
                    end else begin
                        n_up_cmd.op = OP_INSERT;
                    end
                end
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (r_lo_cmd.op == OP_INSERT) n_lo_cnt = r_lo_cnt + CNT_W'(1);
                if (r_up_cmd.op == OP_INSERT) n_up_cnt = r_up_cnt + CNT_W'(1);
                n_lo_cmd.op = OP_NOP;
                n_up_cmd.op = OP_NOP;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                n_strobe  = 1'b1;
                n_dropped = r_drop;
                n_held    = HELD_W'(w_total);
                if (!r_drop) begin
                    if (w_even) n_median = MED_W'(w_lo_top) + MED_W'(w_up_top);
                    else n_median = {w_lo_top, 1'b0};
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lo_cmd <= '{op: OP_NOP, x: '0};
            r_up_cmd <= '{op: OP_NOP, x: '0};
            r_drop   <= 1'b0;
            r_lo_cnt <= '0;
            r_up_cnt <= '0;
            r_strobe <= 1'b0;
            r_median <= '0;
        end else begin
            r_state  <= n_state;
            r_lo_cmd <= n_lo_cmd;
            r_up_cmd <= n_up_cmd;
            r_drop   <= n_drop;
            r_lo_cnt <= n_lo_cnt;
            r_up_cnt <= n_up_cnt;
            r_strobe <= n_strobe;
            r_median <= n_median;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_dropped <= n_dropped;
        r_held    <= n_held;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_median_x2    = r_median;
    assign o_dropped      = r_dropped;
    assign o_samples_held = r_held;

    `RMTH_ASSERT_NOW(a_halves_balanced, i_clk, i_rst_n, 1'b1,
        (r_lo_cnt == r_up_cnt) || (r_lo_cnt == r_up_cnt + CNT_W'(1)))
    `RMTH_ASSERT_NOW(a_word_answered, i_clk, i_rst_n,
        $past(start && !busy && i_rst_n, 4), r_strobe)
    `RMTH_ASSERT_NOW(a_strobe_from_emit, i_clk, i_rst_n, r_strobe,
        $past(r_state == S_EMIT))
    `RMTH_ASSERT_NOW(a_drop_only_full, i_clk, i_rst_n, r_strobe && r_dropped,
        (r_lo_cnt == CNT_W'(HALF_DEPTH)) && (r_up_cnt == CNT_W'(HALF_DEPTH)))

endmodule
